FILE: hw/rtl/pwg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwg_pkg
// Types, widths and register codes shared by the pulse waveform generator.
// ----------------------------------------------------------------------------
package pwg_pkg;

    localparam int LEVEL_BITS     = 24;
    localparam int TIME_BITS      = 32;
    localparam int MAG_BITS       = LEVEL_BITS + 1;
    localparam int PROD_BITS      = MAG_BITS + TIME_BITS;
    localparam int IN_DATA_BITS   = ((TIME_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = ((LEVEL_BITS + 2 + 7) / 8) * 8;
    localparam int FIFO_DEPTH     = 4;
    localparam int PTR_BITS       = $clog2(FIFO_DEPTH);
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_LEVEL   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSE_LEVEL  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_DELAY  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RISE_TICKS   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FALL_TICKS   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH_TICKS  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PERIOD_TICKS = 3'd6;

    typedef enum logic [1:0] {
        SEG_BASE = 2'd0,
        SEG_RISE = 2'd1,
        SEG_TOP  = 2'd2,
        SEG_FALL = 2'd3
    } pwg_seg_t;

    typedef struct packed {
        logic signed [LEVEL_BITS-1:0] base_level;
        logic signed [LEVEL_BITS-1:0] pulse_level;
        logic [TIME_BITS-1:0]         start_delay;
        logic [TIME_BITS-1:0]         rise_ticks;
        logic [TIME_BITS-1:0]         fall_ticks;
        logic [TIME_BITS-1:0]         width_ticks;
        logic [TIME_BITS-1:0]         period_ticks;
    } pwg_cfg_t;

    // one classified sample waiting for the back end
    typedef struct packed {
        logic                 after;
        logic [TIME_BITS-1:0] offset;
    } pwg_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pwg_q_status_t;

endpackage

FILE: hw/rtl/pwg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwg_front
// Accepts sample times, compares them against the start delay and queues the
// offset into the pulse train.
// ----------------------------------------------------------------------------
module pwg_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pwg_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input  logic [pwg_pkg::TIME_BITS-1:0]      start_delay,
    input  pwg_pkg::pwg_q_status_t             q_status,
    output logic                               push,
    output pwg_pkg::pwg_item_t                 push_item
);

    logic [pwg_pkg::TIME_BITS-1:0] now;

    assign now       = s_tdata[pwg_pkg::TIME_BITS-1:0];
    assign s_tready  = !q_status.full;
    assign push      = s_tvalid && !q_status.full;

    always_comb begin
        push_item.after  = now > start_delay;
        push_item.offset = now - start_delay;
    end

endmodule

FILE: hw/rtl/pwg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwg_fifo
// Short queue between the front and back ends.
// ----------------------------------------------------------------------------
module pwg_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  pwg_pkg::pwg_item_t     push_item,
    input  logic                   pop,
    output pwg_pkg::pwg_item_t     head_item,
    output pwg_pkg::pwg_q_status_t q_status
);

    pwg_pkg::pwg_item_t              mem_reg [pwg_pkg::FIFO_DEPTH];
    logic [pwg_pkg::PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [pwg_pkg::PTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [pwg_pkg::PTR_BITS:0]      count_reg, count_next;

    assign head_item      = mem_reg[rd_ptr_reg];
    assign q_status.full  = count_reg == (pwg_pkg::PTR_BITS+1)'(pwg_pkg::FIFO_DEPTH);
    assign q_status.empty = count_reg == '0;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (pwg_pkg::PTR_BITS+1)'(push)
                    - (pwg_pkg::PTR_BITS+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/pwg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwg_back
// Pipelined period modulo, segment classification, ramp multiply and
// pipelined ramp divide, ending in the output register.
// ----------------------------------------------------------------------------
module pwg_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pwg_pkg::pwg_cfg_t                  cfg,
    input  pwg_pkg::pwg_item_t                 head_item,
    input  pwg_pkg::pwg_q_status_t             q_status,
    output logic                               pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pwg_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

    localparam int TB = pwg_pkg::TIME_BITS;
    localparam int LB = pwg_pkg::LEVEL_BITS;
    localparam int MB = pwg_pkg::MAG_BITS;
    localparam int PB = pwg_pkg::PROD_BITS;

    logic          adv;
    logic [TB-1:0] per;

    // whole pipeline moves together; it holds while the output is stalled
    assign adv = !m_tvalid || m_tready;
    assign pop = adv && !q_status.empty;
    assign per = (cfg.period_ticks == '0) ? TB'(1) : cfg.period_ticks;

    // ---------------- modulo stages ----------------
    logic          md_valid_reg [TB];
    logic          md_after_reg [TB];
    logic [TB-1:0] md_x_reg     [TB];
    logic [TB-1:0] md_r_reg     [TB];

    for (genvar k = 0; k < TB; k++) begin : g_mod
        logic          v_in, a_in;
        logic [TB-1:0] x_in, r_in, r_out;
        logic [TB:0]   r_sh;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in = pop;
            assign a_in = head_item.after;
            assign x_in = head_item.offset;
            assign r_in = '0;
        end else begin : g_rest
            assign v_in = md_valid_reg[k-1];
            assign a_in = md_after_reg[k-1];
            assign x_in = md_x_reg[k-1];
            assign r_in = md_r_reg[k-1];
        end

        always_comb begin
            r_sh  = {r_in, x_in[TB-1]};
            ge    = r_sh >= {1'b0, per};
            r_out = ge ? TB'(r_sh - {1'b0, per}) : r_sh[TB-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                md_valid_reg[k] <= 1'b0;
            end else if (adv) begin
                md_valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                md_after_reg[k] <= a_in;
                md_x_reg[k]     <= x_in << 1;
                md_r_reg[k]     <= r_out;
            end
        end
    end

    // ---------------- classify ----------------
    logic                 cl_valid_reg;
    pwg_pkg::pwg_seg_t    cl_seg_reg, cl_seg_next;
    logic signed [LB-1:0] cl_from_reg, cl_from_next;
    logic [MB-1:0]        cl_mag_reg, cl_mag_next;
    logic                 cl_neg_reg, cl_neg_next;
    logic [TB-1:0]        cl_num_reg, cl_num_next;
    logic [TB-1:0]        cl_den_reg, cl_den_next;

    logic [TB-1:0] t;
    logic [TB:0]   top_end;
    logic [TB+1:0] fall_end;
    logic [MB-1:0] diff;

    assign t = md_r_reg[TB-1];

    always_comb begin
        top_end  = {1'b0, cfg.rise_ticks} + {1'b0, cfg.width_ticks};
        fall_end = {1'b0, top_end} + {2'b0, cfg.fall_ticks};
        cl_seg_next  = pwg_pkg::SEG_BASE;
        cl_from_next = cfg.base_level;
        diff         = '0;
        cl_num_next  = '0;
        cl_den_next  = TB'(1);
        if (md_after_reg[TB-1]) begin
            if (cfg.rise_ticks != '0 && t <= cfg.rise_ticks) begin
                cl_seg_next  = pwg_pkg::SEG_RISE;
                diff         = {cfg.pulse_level[LB-1], cfg.pulse_level}
                             - {cfg.base_level[LB-1], cfg.base_level};
                cl_num_next  = t;
                cl_den_next  = cfg.rise_ticks;
            end else if ({1'b0, t} <= top_end) begin
                cl_seg_next  = pwg_pkg::SEG_TOP;
                cl_from_next = cfg.pulse_level;
            end else if (cfg.fall_ticks != '0 && {2'b0, t} <= fall_end) begin
                cl_seg_next  = pwg_pkg::SEG_FALL;
                cl_from_next = cfg.pulse_level;
                diff         = {cfg.base_level[LB-1], cfg.base_level}
                             - {cfg.pulse_level[LB-1], cfg.pulse_level};
                cl_num_next  = TB'({1'b0, t} - top_end);
                cl_den_next  = cfg.fall_ticks;
            end
        end
        cl_neg_next = diff[MB-1];
        cl_mag_next = cl_neg_next ? MB'(-diff) : diff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cl_valid_reg <= 1'b0;
        end else if (adv) begin
            cl_valid_reg <= md_valid_reg[TB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cl_seg_reg  <= cl_seg_next;
            cl_from_reg <= cl_from_next;
            cl_mag_reg  <= cl_mag_next;
            cl_neg_reg  <= cl_neg_next;
            cl_num_reg  <= cl_num_next;
            cl_den_reg  <= cl_den_next;
        end
    end

    // ---------------- multiply ----------------
    logic                 mu_valid_reg;
    pwg_pkg::pwg_seg_t    mu_seg_reg;
    logic signed [LB-1:0] mu_from_reg;
    logic                 mu_neg_reg;
    logic [TB-1:0]        mu_den_reg;
    logic [PB-1:0]        mu_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_valid_reg <= 1'b0;
        end else if (adv) begin
            mu_valid_reg <= cl_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mu_seg_reg  <= cl_seg_reg;
            mu_from_reg <= cl_from_reg;
            mu_neg_reg  <= cl_neg_reg;
            mu_den_reg  <= cl_den_reg;
            mu_prod_reg <= PB'(cl_mag_reg) * PB'(cl_num_reg);
        end
    end

    // ---------------- divide stages ----------------
    // the product is below den << MAG_BITS, so its top bits start below den
    logic                 dv_valid_reg [MB];
    pwg_pkg::pwg_seg_t    dv_seg_reg   [MB];
    logic signed [LB-1:0] dv_from_reg  [MB];
    logic                 dv_neg_reg   [MB];
    logic [TB-1:0]        dv_den_reg   [MB];
    logic [TB-1:0]        dv_r_reg     [MB];
    logic [MB-1:0]        dv_lo_reg    [MB];
    logic [MB-1:0]        dv_q_reg     [MB];

    for (genvar k = 0; k < MB; k++) begin : g_div
        logic                 v_in, n_in;
        pwg_pkg::pwg_seg_t    s_in;
        logic signed [LB-1:0] f_in;
        logic [TB-1:0]        d_in, r_in, r_out;
        logic [MB-1:0]        lo_in, q_in;
        logic [TB:0]          r_sh;
        logic                 ge;

        if (k == 0) begin : g_first
            assign v_in  = mu_valid_reg;
            assign s_in  = mu_seg_reg;
            assign f_in  = mu_from_reg;
            assign n_in  = mu_neg_reg;
            assign d_in  = mu_den_reg;
            assign r_in  = mu_prod_reg[PB-1:MB];
            assign lo_in = mu_prod_reg[MB-1:0];
            assign q_in  = '0;
        end else begin : g_rest
            assign v_in  = dv_valid_reg[k-1];
            assign s_in  = dv_seg_reg[k-1];
            assign f_in  = dv_from_reg[k-1];
            assign n_in  = dv_neg_reg[k-1];
            assign d_in  = dv_den_reg[k-1];
            assign r_in  = dv_r_reg[k-1];
            assign lo_in = dv_lo_reg[k-1];
            assign q_in  = dv_q_reg[k-1];
        end

        always_comb begin
            r_sh  = {r_in, lo_in[MB-1]};
            ge    = r_sh >= {1'b0, d_in};
            r_out = ge ? TB'(r_sh - {1'b0, d_in}) : r_sh[TB-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_seg_reg[k]  <= s_in;
                dv_from_reg[k] <= f_in;
                dv_neg_reg[k]  <= n_in;
                dv_den_reg[k]  <= d_in;
                dv_r_reg[k]    <= r_out;
                dv_lo_reg[k]   <= lo_in << 1;
                dv_q_reg[k]    <= {q_in[MB-2:0], ge};
            end
        end
    end

    // ---------------- output register ----------------
    logic                 out_valid_reg;
    pwg_pkg::pwg_seg_t    out_seg_reg;
    logic [LB-1:0]        out_level_reg, out_level_next;
    logic [MB-1:0]        q_last;
    logic [MB-1:0]        from_ext;

    assign q_last   = dv_q_reg[MB-1];
    assign from_ext = {dv_from_reg[MB-1][LB-1], dv_from_reg[MB-1]};

    always_comb begin
        out_level_next = dv_neg_reg[MB-1] ? LB'(from_ext - q_last)
                                          : LB'(from_ext + q_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_valid_reg[MB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_seg_reg   <= dv_seg_reg[MB-1];
            out_level_reg <= out_level_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pwg_pkg::OUT_DATA_BITS'({out_seg_reg, out_level_reg});

endmodule

FILE: hw/rtl/pulse_waveform_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_waveform_generator
// Periodic trapezoid pulse source: one sample time in, one level out.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_        in         tdata: sample_time[31:0]
//  m_        out        tdata: level[23:0], segment[25:24], zero pad above
//  cfg_      in         cfg_index selects register, cfg_data holds value
//
// One sample per clock sustained while the output is not stalled; the modulo
// and ramp divide pipelines each resolve one bit per stage.
// aresetn is synchronous; config registers return to period 1, all others zero.
// A stalled output freezes the whole back end; the 4-entry queue keeps
// accepting until it fills.
// ----------------------------------------------------------------------------
module pulse_waveform_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pwg_pkg::IN_DATA_BITS-1:0]    s_tdata,   // sample_time
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pwg_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // level, segment
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pwg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pwg_pkg::TIME_BITS-1:0]       cfg_data
);

    pwg_pkg::pwg_cfg_t      cfg_reg;
    pwg_pkg::pwg_q_status_t q_status;
    pwg_pkg::pwg_item_t     push_item, head_item;
    logic                   push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_level   <= '0;
            cfg_reg.pulse_level  <= '0;
            cfg_reg.start_delay  <= '0;
            cfg_reg.rise_ticks   <= '0;
            cfg_reg.fall_ticks   <= '0;
            cfg_reg.width_ticks  <= '0;
            cfg_reg.period_ticks <= pwg_pkg::TIME_BITS'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pwg_pkg::CFG_BASE_LEVEL:
                    cfg_reg.base_level <= cfg_data[pwg_pkg::LEVEL_BITS-1:0];
                pwg_pkg::CFG_PULSE_LEVEL:
                    cfg_reg.pulse_level <= cfg_data[pwg_pkg::LEVEL_BITS-1:0];
                pwg_pkg::CFG_START_DELAY:  cfg_reg.start_delay  <= cfg_data;
                pwg_pkg::CFG_RISE_TICKS:   cfg_reg.rise_ticks   <= cfg_data;
                pwg_pkg::CFG_FALL_TICKS:   cfg_reg.fall_ticks   <= cfg_data;
                pwg_pkg::CFG_WIDTH_TICKS:  cfg_reg.width_ticks  <= cfg_data;
                pwg_pkg::CFG_PERIOD_TICKS: cfg_reg.period_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    pwg_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .start_delay (cfg_reg.start_delay),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    pwg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    pwg_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .head_item (head_item),
        .q_status  (q_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: bench/pulse_waveform_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_waveform_generator_tb
// Self-checking bench for the trapezoid pulse source. Sample times are
// streamed in with random gaps and output back-pressure, and each level and
// segment is checked against a behavioural waveform calculation held here.
// ----------------------------------------------------------------------------
module pulse_waveform_generator_tb;

    localparam int LEVEL_BITS     = pwg_pkg::LEVEL_BITS;
    localparam int TIME_BITS      = pwg_pkg::TIME_BITS;
    localparam int IN_DATA_BITS   = pwg_pkg::IN_DATA_BITS;
    localparam int OUT_DATA_BITS  = pwg_pkg::OUT_DATA_BITS;
    localparam int CFG_INDEX_BITS = pwg_pkg::CFG_INDEX_BITS;
    localparam int LATENCY        = pwg_pkg::TIME_BITS + pwg_pkg::MAG_BITS + 4;

    // index past the last register; writes to it are dropped
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;

    typedef struct {
        logic signed [LEVEL_BITS-1:0] level;
        pwg_pkg::pwg_seg_t            seg;
    } wave_point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_BITS-1:0] s_tdata = '0;       // sample_time
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;            // level, segment, pad
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [TIME_BITS-1:0] cfg_data = '0;

    pulse_waveform_generator dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow registers
    logic signed [LEVEL_BITS-1:0] base_lvl, pulse_lvl;
    logic [TIME_BITS-1:0] delay_t, rise_t, fall_t, width_t, period_t;

    logic [TIME_BITS-1:0] sample_q[$];
    wave_point_t          wave_q[$];
    int errors = 0, n_checked = 0, n_sent = 0;
    int src_idle = 7, sink_idle = 53;
    int hold_cycles = 0;

    function automatic logic signed [LEVEL_BITS-1:0] ramp_level(
        logic signed [LEVEL_BITS-1:0] from, logic signed [LEVEL_BITS-1:0] to,
        logic [TIME_BITS-1:0] num, logic [TIME_BITS-1:0] den);
        logic signed [LEVEL_BITS+1:0] diff;
        logic [LEVEL_BITS+1:0] mag;
        logic [LEVEL_BITS+TIME_BITS+1:0] step;
        diff = $signed({to[LEVEL_BITS-1], to}) - $signed({from[LEVEL_BITS-1], from});
        mag  = diff < 0 ? -diff : diff;
        step = (mag * num) / den;
        if (diff < 0) return LEVEL_BITS'($signed({2'b0, from}) - step);
        return LEVEL_BITS'(from + step);
    endfunction

    function automatic wave_point_t pulse_value(logic [TIME_BITS-1:0] now);
        wave_point_t p;
        logic [TIME_BITS-1:0] per;
        logic [TIME_BITS-1:0] t;
        logic [TIME_BITS+1:0] top_end, fall_end;
        p.level = base_lvl;
        p.seg   = pwg_pkg::SEG_BASE;
        per = (period_t == 0) ? 1 : period_t;
        if (now > delay_t) begin
            t = (now - delay_t) % per;
            top_end  = rise_t + width_t;
            fall_end = top_end + fall_t;
            if (rise_t != 0 && t <= rise_t) begin
                p.level = ramp_level(base_lvl, pulse_lvl, t, rise_t);
                p.seg   = pwg_pkg::SEG_RISE;
            end else if (t <= top_end) begin
                p.level = pulse_lvl;
                p.seg   = pwg_pkg::SEG_TOP;
            end else if (fall_t != 0 && t <= fall_end) begin
                p.level = ramp_level(pulse_lvl, base_lvl, TIME_BITS'(t - top_end), fall_t);
                p.seg   = pwg_pkg::SEG_FALL;
            end
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $realtime, what);
        errors++;
    endtask

    // driver: prediction made at acceptance
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                wave_q.push_back(pulse_value(s_tdata[TIME_BITS-1:0]));
                n_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= src_idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_DATA_BITS'(sample_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and sink; a long hold-off is counted down here
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (wave_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    wave_point_t e;
                    e = wave_q.pop_front();
                    if (m_tdata[LEVEL_BITS-1:0] !== e.level)
                        report_mismatch($sformatf("level %0d, expected %0d",
                            $signed(m_tdata[LEVEL_BITS-1:0]), e.level));
                    if (m_tdata[LEVEL_BITS+1:LEVEL_BITS] !== e.seg)
                        report_mismatch($sformatf("segment %0d, expected %0d",
                            m_tdata[LEVEL_BITS+1:LEVEL_BITS], e.seg));
                    n_checked++;
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle);
            end
        end
    end

    // one transaction, then cfg_valid is dropped before the next
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [TIME_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            pwg_pkg::CFG_BASE_LEVEL:   base_lvl  = val[LEVEL_BITS-1:0];
            pwg_pkg::CFG_PULSE_LEVEL:  pulse_lvl = val[LEVEL_BITS-1:0];
            pwg_pkg::CFG_START_DELAY:  delay_t   = val;
            pwg_pkg::CFG_RISE_TICKS:   rise_t    = val;
            pwg_pkg::CFG_FALL_TICKS:   fall_t    = val;
            pwg_pkg::CFG_WIDTH_TICKS:  width_t   = val;
            pwg_pkg::CFG_PERIOD_TICKS: period_t  = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || s_tvalid || wave_q.size() > 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_wave(input logic [TIME_BITS-1:0] b, p, d, r, f, w, per);
        write_reg(pwg_pkg::CFG_BASE_LEVEL, b);
        write_reg(pwg_pkg::CFG_PULSE_LEVEL, p);
        write_reg(pwg_pkg::CFG_START_DELAY, d);
        write_reg(pwg_pkg::CFG_RISE_TICKS, r);
        write_reg(pwg_pkg::CFG_FALL_TICKS, f);
        write_reg(pwg_pkg::CFG_WIDTH_TICKS, w);
        write_reg(pwg_pkg::CFG_PERIOD_TICKS, per);
    endtask

    // random samples over a few periods around the delay; one in ten fully random
    task automatic load_random(input int n);
        longint unsigned span;
        repeat (n) begin
            span = (period_t == 0) ? 1 : period_t;
            if ($urandom_range(9) == 0) sample_q.push_back($urandom());
            else sample_q.push_back(TIME_BITS'(delay_t + $urandom() % (span * 3 + 2) - 1));
        end
    endtask

    initial begin
        base_lvl = '0; pulse_lvl = '0; delay_t = '0; rise_t = '0;
        fall_t = '0; width_t = '0; period_t = 1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values first, then directed corners
        sample_q = '{0, 1, 32'hFFFF_FFFF};
        drain();
        set_wave(32'h80_0000, 32'h7F_FFFF, 10, 4, 3, 2, 20);
        sample_q = '{0, 10, 11, 12, 14, 15, 16, 17, 18, 19, 20, 21, 29, 30, 31,
                     32'hFFFF_FFFF};
        drain();
        // zero ramps, zero period, pulse longer than period
        set_wave(32'h7F_FFFF, 32'h80_0000, 0, 0, 0, 5, 0);
        sample_q = '{0, 1, 2, 32'h8000_0000};
        drain();
        set_wave(-100, 100, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        sample_q = '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 0};
        drain();
        write_reg(CFG_UNUSED_INDEX, 32'h1234);   // out-of-range index, ignored
        set_wave(5, -7, 3, 0, 6, 0, 9);
        sample_q = '{3, 4, 5, 9, 10, 11, 12};
        drain();

        // phase 1: 53% sink stall, plus a long hold-off
        set_wave($urandom(), $urandom(), $urandom_range(50), $urandom_range(30),
                 $urandom_range(30), $urandom_range(30), $urandom_range(1, 120));
        hold_cycles = 200;
        load_random(60);
        wait (hold_cycles == 0);
        drain();
        repeat (3) begin
            set_wave($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom());
            load_random(30);
            drain();
        end
        // phase 2: sender idles more
        src_idle = 53; sink_idle = 7;
        repeat (4) begin
            set_wave($urandom(), $urandom(), $urandom_range(100), $urandom_range(500),
                     $urandom_range(500), $urandom_range(500), $urandom_range(0, 2000));
            load_random(40);
            drain();
        end
        // phase 3: no idling
        src_idle = 0; sink_idle = 0;
        repeat (4) begin
            set_wave($urandom(), $urandom(), $urandom_range(20), $urandom_range(9),
                     $urandom_range(9), $urandom_range(9), $urandom_range(1, 40));
            load_random(40);
            drain();
        end

        $display("Covered %0d samples over several pulse shapes, including zero ramps,",
                 n_checked);
        $display("zero period, extreme levels and times, and stalled output.");
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/pwg_pkg.sv
hw/rtl/pwg_front.sv
hw/rtl/pwg_fifo.sv
hw/rtl/pwg_back.sv
hw/rtl/pulse_waveform_generator.sv
bench/pulse_waveform_generator_tb.sv
